// File: src/stok_pkg.sv
package stok_pkg;

  localparam int unsigned PositionBitsDef = 32;
  localparam int unsigned KeywordMaxDef   = 6;
  localparam int unsigned QueueDepthDef   = 2;
  localparam int unsigned MaxTokens       = 3;

  localparam logic [4:0] K_LBRACE  = 5'd0;
  localparam logic [4:0] K_RBRACE  = 5'd1;
  localparam logic [4:0] K_LPAREN  = 5'd2;
  localparam logic [4:0] K_RPAREN  = 5'd3;
  localparam logic [4:0] K_SEMI    = 5'd4;
  localparam logic [4:0] K_COMMA   = 5'd5;
  localparam logic [4:0] K_IDENT   = 5'd6;
  localparam logic [4:0] K_NUMBER  = 5'd7;
  localparam logic [4:0] K_STRING  = 5'd8;
  localparam logic [4:0] K_KW_BASE = 5'd9;
  localparam logic [4:0] K_TRUE    = 5'd14;
  localparam logic [4:0] K_PLUS    = 5'd17;
  localparam logic [4:0] K_MINUS   = 5'd18;
  localparam logic [4:0] K_STAR    = 5'd19;
  localparam logic [4:0] K_SLASH   = 5'd20;
  localparam logic [4:0] K_PERCENT = 5'd21;
  localparam logic [4:0] K_EQ      = 5'd22;
  localparam logic [4:0] K_EQEQ    = 5'd23;
  localparam logic [4:0] K_LT      = 5'd24;
  localparam logic [4:0] K_GT      = 5'd25;
  localparam logic [4:0] K_BANG    = 5'd26;
  localparam logic [4:0] K_END     = 5'd27;
  localparam logic [4:0] K_UNKNOWN = 5'd28;
  localparam logic [4:0] K_UNTERM  = 5'd29;
  localparam logic [4:0] K_NONE    = 5'd31;

  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [63:0] KwText [8] = '{
    64'("if"), 64'("else"), 64'("while"), 64'("return"),
    64'("const"), 64'("true"), 64'("false"), 64'("define")};
  localparam logic [3:0] KwLen [8] = '{
    4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd4, 4'd5, 4'd6};

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] line;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] literal;
    logic        ovf;
    logic [7:0]  uchar;
  } tok_t;

  typedef struct packed {
    tok_t [MaxTokens-1:0] tok;
    logic [1:0]           count;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  // single-character tokens, K_NONE where the byte is not one
  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h7b: k = K_LBRACE;
      8'h7d: k = K_RBRACE;
      8'h28: k = K_LPAREN;
      8'h29: k = K_RPAREN;
      8'h3b: k = K_SEMI;
      8'h2c: k = K_COMMA;
      8'h2b: k = K_PLUS;
      8'h2d: k = K_MINUS;
      8'h2a: k = K_STAR;
      8'h2f: k = K_SLASH;
      8'h25: k = K_PERCENT;
      8'h3c: k = K_LT;
      8'h3e: k = K_GT;
      8'h21: k = K_BANG;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [63:0] buf_v, input logic [3:0] len);
    logic [4:0] k;
    k = K_IDENT;
    for (int i = 7; i >= 0; i--) begin
      if (len == KwLen[i] && buf_v == KwText[i]) k = K_KW_BASE + 5'(i);
    end
    return k;
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [31:0] line,
                                  input logic [31:0] off, input logic [31:0] len,
                                  input logic [31:0] lit, input logic ovf,
                                  input logic [7:0] uch);
    tok_t t;
    t.kind = kind; t.line = line; t.offset = off; t.length = len;
    t.literal = lit; t.ovf = ovf; t.uchar = uch;
    return t;
  endfunction

endpackage

// File: src/stok_front.sv
module stok_front import stok_pkg::*; #(
  parameter int unsigned POSITION_BITS     = PositionBitsDef,
  parameter int unsigned KEYWORD_MAX_CHARS = KeywordMaxDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  logic [7:0]    char_byte_i,
  input  logic          end_of_source_i,
  output logic          emit_o,
  output bundle_t       bundle_o
);

  localparam int unsigned P  = POSITION_BITS;
  localparam int unsigned KW = 8 * KEYWORD_MAX_CHARS;
  localparam int unsigned CW = $clog2(KEYWORD_MAX_CHARS + 2);

  typedef enum logic [2:0] {
    M_IDLE, M_EQ, M_INT, M_DOT, M_FRAC, M_IDENT, M_STR
  } mode_e;

  mode_e         mode_q, mode_d;
  logic [P-1:0]  pos_q, pos_d, start_q, start_d;
  logic [31:0]   line_q, line_d, sline_q, sline_d;
  logic [KW-1:0] kw_q, kw_d;
  logic [CW-1:0] kcnt_q, kcnt_d;
  logic [30:0]   num_q, num_d;
  logic          ovf_q, ovf_d;

  function automatic logic [31:0] to32(input logic [P-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  logic [P-1:0]  dot_pos;
  logic [31:0]   num_tok_len, cur_len, dot_len;
  logic [35:0]   num_next;
  logic [63:0]   kw_wide;
  logic [4:0]    id_kind;
  tok_t          num_tok, dot_tok, id_tok;

  assign dot_pos     = pos_q - P'(1);
  assign cur_len     = to32(pos_q - start_q);
  assign dot_len     = to32(dot_pos - start_q);
  assign num_next    = 36'(num_q) * 36'd10 + 36'(char_byte_i - 8'h30);
  assign kw_wide     = 64'(kw_q);
  assign id_kind     = (kcnt_q <= CW'(KEYWORD_MAX_CHARS)) ? kw_kind(kw_wide, 4'(kcnt_q))
                                                          : K_IDENT;
  assign num_tok_len = cur_len;
  assign num_tok = mk_tok(K_NUMBER, sline_q, to32(start_q), num_tok_len, 32'(num_q), ovf_q,
                          8'd0);
  assign dot_tok = mk_tok(K_UNKNOWN, line_q, to32(dot_pos), 32'd1, 32'd0, 1'b0, CH_DOT);
  assign id_tok  = mk_tok(id_kind, sline_q, to32(start_q), cur_len,
                          {31'd0, id_kind == K_TRUE}, 1'b0, 8'd0);

  always_comb begin
    logic       redo;
    logic [7:0] c;
    logic [4:0] ok;
    bundle_t    b;
    tok_t       t;
    c      = char_byte_i;
    redo   = 1'b0;
    b      = '0;
    t      = '0;
    ok     = op_kind(c);
    mode_d = mode_q; pos_d = pos_q; start_d = start_q;
    line_d = line_q; sline_d = sline_q; kw_d = kw_q; kcnt_d = kcnt_q;
    num_d  = num_q; ovf_d = ovf_q;
    if (end_of_source_i) begin
      case (mode_q)
        M_EQ: begin
          b.tok[0] = mk_tok(K_EQ, sline_q, to32(start_q), 32'd1, 32'd0, 1'b0, 8'd0);
          b.count  = 2'd1;
        end
        M_INT, M_FRAC: begin
          b.tok[0] = num_tok; b.count = 2'd1;
        end
        M_DOT: begin
          t = num_tok; t.length = dot_len;
          b.tok[0] = t; b.tok[1] = dot_tok; b.count = 2'd2;
        end
        M_IDENT: begin
          b.tok[0] = id_tok; b.count = 2'd1;
        end
        M_STR: begin
          b.tok[0] = mk_tok(K_UNTERM, sline_q, to32(start_q), cur_len, 32'd0, 1'b0, 8'd0);
          b.count  = 2'd1;
        end
        default: ;
      endcase
      b.tok[b.count] = mk_tok(K_END, line_q, to32(pos_q), 32'd0, 32'd0, 1'b0, 8'd0);
      b.count = b.count + 2'd1;
      mode_d = M_IDLE; pos_d = '0; start_d = '0; line_d = 32'd1; sline_d = 32'd1;
      kw_d = '0; kcnt_d = '0; num_d = '0; ovf_d = 1'b0;
    end else begin
      redo = 1'b1;
      case (mode_q)
        M_EQ: begin
          mode_d = M_IDLE;
          if (c == CH_EQ) begin
            b.tok[0] = mk_tok(K_EQEQ, sline_q, to32(start_q), 32'd2, 32'd0, 1'b0, 8'd0);
            redo = 1'b0;
          end else begin
            b.tok[0] = mk_tok(K_EQ, sline_q, to32(start_q), 32'd1, 32'd0, 1'b0, 8'd0);
          end
          b.count = 2'd1;
        end
        M_INT: begin
          redo = 1'b0;
          if (is_digit(c)) begin
            if (num_next > 36'h07fff_ffff) begin
              num_d = '1; ovf_d = 1'b1;
            end else begin
              num_d = num_next[30:0];
            end
          end else if (c == CH_DOT) begin
            mode_d = M_DOT;
          end else begin
            b.tok[0] = num_tok; b.count = 2'd1;
            mode_d = M_IDLE; redo = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            mode_d = M_FRAC; redo = 1'b0;
          end else begin
            t = num_tok; t.length = dot_len;
            b.tok[0] = t; b.tok[1] = dot_tok; b.count = 2'd2;
            mode_d = M_IDLE;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            redo = 1'b0;
          end else begin
            b.tok[0] = num_tok; b.count = 2'd1; mode_d = M_IDLE;
          end
        end
        M_IDENT: begin
          if (is_digit(c) || is_alpha(c)) begin
            if (kcnt_q <= CW'(KEYWORD_MAX_CHARS)) begin
              kw_d   = {kw_q[KW-9:0], c};
              kcnt_d = kcnt_q + CW'(1);
            end
            redo = 1'b0;
          end else begin
            b.tok[0] = id_tok; b.count = 2'd1; mode_d = M_IDLE;
          end
        end
        M_STR: begin
          redo = 1'b0;
          if (c == CH_QUOTE) begin
            b.tok[0] = mk_tok(K_STRING, sline_q, to32(start_q), cur_len, 32'd0, 1'b0, 8'd0);
            b.count  = 2'd1;
            mode_d   = M_IDLE;
          end else if (c == CH_LF && line_q != '1) begin
            line_d = line_q + 32'd1;
          end
        end
        default: mode_d = M_IDLE;
      endcase
      if (redo) begin
        if (is_space(c)) begin
          if (c == CH_LF && line_q != '1) line_d = line_q + 32'd1;
        end else if (ok != K_NONE) begin
          b.tok[b.count] = mk_tok(ok, line_q, to32(pos_q), 32'd1, 32'd0, 1'b0, 8'd0);
          b.count = b.count + 2'd1;
        end else begin
          start_d = pos_q;
          sline_d = line_q;
          if (c == CH_EQ) begin
            mode_d = M_EQ;
          end else if (c == CH_QUOTE) begin
            start_d = pos_q + P'(1);
            mode_d  = M_STR;
          end else if (is_digit(c)) begin
            num_d = 31'(c - 8'h30); ovf_d = 1'b0; mode_d = M_INT;
          end else if (is_alpha(c)) begin
            kw_d = KW'(c); kcnt_d = CW'(1); mode_d = M_IDENT;
          end else begin
            b.tok[b.count] = mk_tok(K_UNKNOWN, line_q, to32(pos_q), 32'd1, 32'd0, 1'b0, c);
            b.count = b.count + 2'd1;
          end
        end
      end
      pos_d = pos_q + P'(1);
    end
    bundle_o = b;
    emit_o   = take_i && (b.count != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; pos_q <= '0; start_q <= '0; line_q <= 32'd1; sline_q <= 32'd1;
      kw_q <= '0; kcnt_q <= '0; num_q <= '0; ovf_q <= 1'b0;
    end else if (take_i) begin
      mode_q <= mode_d; pos_q <= pos_d; start_q <= start_d; line_q <= line_d;
      sline_q <= sline_d; kw_q <= kw_d; kcnt_q <= kcnt_d; num_q <= num_d; ovf_q <= ovf_d;
    end
  end

endmodule

// File: src/stok_fifo.sv
module stok_fifo import stok_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  bundle_t wdata_i,
  output logic    full_o,
  input  logic    rd_i,
  output logic    avail_o,
  output bundle_t rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  bundle_t       mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = cnt_q == NW'(DEPTH);
  assign avail_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
      if (rd_i) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
      cnt_q <= cnt_q + NW'(wr_i) - NW'(rd_i);
    end
  end

endmodule

// File: src/stok_back.sv
module stok_back import stok_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    avail_i,
  input  bundle_t head_i,
  output logic    deq_o,
  input  logic    pop_i,
  output logic    empty_o,
  output tok_t    tok_o,
  output logic    last_o
);

  logic [1:0] idx_q;
  logic       ov_q, last_q;
  tok_t       out_q, pick;
  logic       load, is_last;

  always_comb begin
    case (idx_q)
      2'd0: pick = head_i.tok[0];
      2'd1: pick = head_i.tok[1];
      2'd2: pick = head_i.tok[2];
      default: pick = head_i.tok[0];
    endcase
  end

  assign load    = avail_i && (!ov_q || pop_i);
  assign is_last = idx_q == head_i.count - 2'd1;
  assign deq_o   = load && is_last;
  assign empty_o = !ov_q;
  assign tok_o   = out_q;
  assign last_o  = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q  <= pick;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0; ov_q <= 1'b0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule

// File: src/source_tokenizer.sv
// channel   | handshake    | payload
// source    | push / full  | char_byte_i, end_of_source_i
// tokens    | pop / empty  | token_kind_o .. last_of_run_o
// A byte is scanned in the cycle it is taken; its tokens (up to three) go as
// one word into a short queue. Tokens leave through an output register, one
// per cycle unless pop stalls, so a run of single-token bytes streams at one
// per cycle; a multi-token byte holds the back end till all leave. full rises
// when the queue is full. Reset returns to line 1, offset 0, no queued tokens.
module source_tokenizer import stok_pkg::*; #(
  parameter int unsigned POSITION_BITS     = PositionBitsDef,
  parameter int unsigned KEYWORD_MAX_CHARS = KeywordMaxDef,
  parameter int unsigned QUEUE_DEPTH       = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte_i,
  input  logic        end_of_source_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  token_kind_o,
  output logic [31:0] token_line_o,
  output logic [31:0] start_offset_o,
  output logic [31:0] token_length_o,
  output logic signed [31:0] literal_value_o,
  output logic        number_overflow_o,
  output logic [7:0]  unknown_char_o,
  output logic        last_of_run_o
);

  logic    take, emit, deq, avail;
  bundle_t wb, hb;
  tok_t    t;

  assign take = push && !full;

  stok_front #(
    .POSITION_BITS(POSITION_BITS), .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)
  ) u_front (
    .clk_i, .rst_ni, .take_i(take), .char_byte_i, .end_of_source_i,
    .emit_o(emit), .bundle_o(wb)
  );

  stok_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i, .rst_ni, .wr_i(emit), .wdata_i(wb), .full_o(full),
    .rd_i(deq), .avail_o(avail), .rdata_o(hb)
  );

  stok_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .head_i(hb), .deq_o(deq),
    .pop_i(pop && !empty), .empty_o(empty), .tok_o(t), .last_o(last_of_run_o)
  );

  assign token_kind_o      = t.kind;
  assign token_line_o      = t.line;
  assign start_offset_o    = t.offset;
  assign token_length_o    = t.length;
  assign literal_value_o   = t.literal;
  assign number_overflow_o = t.ovf;
  assign unknown_char_o    = t.uchar;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import stok_pkg::*;

  typedef enum logic [2:0] {
    SM_IDLE, SM_EQ, SM_INT, SM_DOT, SM_FRAC, SM_IDENT, SM_STR
  } scan_e;

  typedef struct {
    logic [4:0]  kind;
    logic [31:0] line;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] literal;
    logic        ovf;
    logic [7:0]  uchar;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_byte_i = '0;
  logic        end_of_source_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [4:0]  token_kind_o;
  logic [31:0] token_line_o;
  logic [31:0] start_offset_o;
  logic [31:0] token_length_o;
  logic signed [31:0] literal_value_o;
  logic        number_overflow_o;
  logic [7:0]  unknown_char_o;
  logic        last_of_run_o;

  source_tokenizer uut (
    .clk_i, .rst_ni, .push, .full, .char_byte_i, .end_of_source_i,
    .empty, .pop, .token_kind_o, .token_line_o, .start_offset_o,
    .token_length_o, .literal_value_o, .number_overflow_o,
    .unknown_char_o, .last_of_run_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // lexer shadow state
  scan_e       mode = SM_IDLE;
  logic [31:0] pos = 0, lines = 1, tstart = 0, tline = 1;
  logic [63:0] kwbuf = 0;
  logic [31:0] numval = 0;
  logic        numovf = 0;
  int          nchars = 0;

  token_t expected_tokens[$];
  token_t run_toks[$];
  int     errors = 0;
  int     hold_off = 0;
  bit     random_stall = 0;

  function automatic bit digit_c(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha_c(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void add_tok(logic [4:0] k, logic [31:0] ln, logic [31:0] off,
                                  logic [31:0] len, logic [31:0] lit, logic ovf,
                                  logic [7:0] uch);
    token_t t;
    t.kind = k; t.line = ln; t.offset = off; t.length = len;
    t.literal = lit; t.ovf = ovf; t.uchar = uch; t.last = 1'b0;
    run_toks.insert(run_toks.size(), t);
  endfunction

  function automatic void lex_reset();
    mode = SM_IDLE; pos = 0; lines = 1; tstart = 0; tline = 1;
    kwbuf = 0; numval = 0; numovf = 0; nchars = 0;
  endfunction

  function automatic void bump_line();
    if (lines != 32'hFFFF_FFFF) lines++;
  endfunction

  function automatic void close_ident();
    logic [4:0] k;
    logic [63:0] txt [8];
    int lens [8];
    k = K_IDENT;
    txt = '{64'("if"), 64'("else"), 64'("while"), 64'("return"),
            64'("const"), 64'("true"), 64'("false"), 64'("define")};
    lens = '{2, 4, 5, 6, 5, 4, 5, 6};
    if (nchars <= 6)
      for (int i = 0; i < 8; i++)
        if (k == K_IDENT && lens[i] == nchars && txt[i] == kwbuf) k = K_KW_BASE + 5'(i);
    add_tok(k, tline, tstart, pos - tstart, (k == K_TRUE) ? 1 : 0, 0, 0);
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    logic [4:0] k;
    if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
      if (c == CH_LF) bump_line();
      return;
    end
    case (c)
      "{": k = K_LBRACE;  "}": k = K_RBRACE; "(": k = K_LPAREN; ")": k = K_RPAREN;
      ";": k = K_SEMI;    ",": k = K_COMMA;  "+": k = K_PLUS;   "-": k = K_MINUS;
      "*": k = K_STAR;    "/": k = K_SLASH;  "%": k = K_PERCENT;
      "<": k = K_LT;      ">": k = K_GT;     "!": k = K_BANG;
      default: k = K_NONE;
    endcase
    if (k != K_NONE) begin
      add_tok(k, lines, pos, 1, 0, 0, 0);
      return;
    end
    tstart = pos;
    tline = lines;
    if (c == CH_EQ) mode = SM_EQ;
    else if (c == CH_QUOTE) begin
      tstart = pos + 1;
      mode = SM_STR;
    end else if (digit_c(c)) begin
      numval = c - "0"; numovf = 0; mode = SM_INT;
    end else if (alpha_c(c)) begin
      kwbuf = c; nchars = 1; mode = SM_IDENT;
    end else add_tok(K_UNKNOWN, lines, pos, 1, 0, 0, c);
  endfunction

  function automatic void lex_step(logic [7:0] c, logic eos);
    bit redo;
    logic [63:0] v;
    logic [31:0] dot;
    redo = 1;
    dot = pos - 1;
    run_toks.delete();
    if (eos) begin
      case (mode)
        SM_EQ: add_tok(K_EQ, tline, tstart, 1, 0, 0, 0);
        SM_INT, SM_FRAC: add_tok(K_NUMBER, tline, tstart, pos - tstart, numval, numovf, 0);
        SM_DOT: begin
          add_tok(K_NUMBER, tline, tstart, dot - tstart, numval, numovf, 0);
          add_tok(K_UNKNOWN, lines, dot, 1, 0, 0, CH_DOT);
        end
        SM_IDENT: close_ident();
        SM_STR: add_tok(K_UNTERM, tline, tstart, pos - tstart, 0, 0, 0);
        default: ;
      endcase
      add_tok(K_END, lines, pos, 0, 0, 0, 0);
      lex_reset();
    end else begin
      case (mode)
        SM_EQ: begin
          mode = SM_IDLE;
          if (c == CH_EQ) begin
            add_tok(K_EQEQ, tline, tstart, 2, 0, 0, 0);
            redo = 0;
          end else add_tok(K_EQ, tline, tstart, 1, 0, 0, 0);
        end
        SM_INT: begin
          redo = 0;
          if (digit_c(c)) begin
            v = 64'(numval) * 10 + (c - "0");
            if (v > 64'h7FFF_FFFF) begin
              v = 64'h7FFF_FFFF; numovf = 1;
            end
            numval = v[31:0];
          end else if (c == CH_DOT) mode = SM_DOT;
          else begin
            add_tok(K_NUMBER, tline, tstart, pos - tstart, numval, numovf, 0);
            mode = SM_IDLE; redo = 1;
          end
        end
        SM_DOT: begin
          if (digit_c(c)) begin
            mode = SM_FRAC; redo = 0;
          end else begin
            add_tok(K_NUMBER, tline, tstart, dot - tstart, numval, numovf, 0);
            add_tok(K_UNKNOWN, lines, dot, 1, 0, 0, CH_DOT);
            mode = SM_IDLE;
          end
        end
        SM_FRAC: begin
          if (digit_c(c)) redo = 0;
          else begin
            add_tok(K_NUMBER, tline, tstart, pos - tstart, numval, numovf, 0);
            mode = SM_IDLE;
          end
        end
        SM_IDENT: begin
          if (digit_c(c) || alpha_c(c)) begin
            if (nchars <= 6) begin
              kwbuf = (kwbuf << 8) | c; nchars++;
            end
            redo = 0;
          end else begin
            close_ident(); mode = SM_IDLE;
          end
        end
        SM_STR: begin
          redo = 0;
          if (c == CH_QUOTE) begin
            add_tok(K_STRING, tline, tstart, pos - tstart, 0, 0, 0);
            mode = SM_IDLE;
          end else if (c == CH_LF) bump_line();
        end
        default: mode = SM_IDLE;
      endcase
      if (redo) lex_idle(c);
      pos++;
    end
    if (run_toks.size() > 0) run_toks[run_toks.size()-1].last = 1'b1;
    foreach (run_toks[i]) expected_tokens.insert(expected_tokens.size(), run_toks[i]);
  endfunction

  // sender: random bursts and gaps
  int burst_left = 0;

  task automatic send_byte(logic [7:0] c, logic eos);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) * ($urandom_range(0, 2) == 0);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    push <= 1'b1;
    char_byte_i <= c;
    end_of_source_i <= eos;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    lex_step(c, eos);
    burst_left--;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic finish_source();
    send_byte(8'h00, 1'b1);
  endtask

  task automatic idle_push();
    push <= 1'b0;
  endtask

  // receiver with its own stall pattern
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      pop <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (random_stall) pop <= ($urandom_range(0, 3) != 0);
    else pop <= 1'b1;
  end

  always @(posedge clk_i) begin
    token_t e;
    if (rst_ni && pop && !empty) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token kind %0d", $time, token_kind_o);
        errors++;
      end else begin
        e = expected_tokens.pop_front();
        if (e.kind !== token_kind_o || e.line !== token_line_o ||
            e.offset !== start_offset_o || e.length !== token_length_o ||
            e.literal !== literal_value_o || e.ovf !== number_overflow_o ||
            e.uchar !== unknown_char_o || e.last !== last_of_run_o) begin
          $display("%0t: expected k%0d l%0d o%0d n%0d v%0d f%0d u%0h r%0d",
                   $time, e.kind, e.line, e.offset, e.length, e.literal,
                   e.ovf, e.uchar, e.last);
          $display("%0t: actual   k%0d l%0d o%0d n%0d v%0d f%0d u%0h r%0d",
                   $time, token_kind_o, token_line_o, start_offset_o,
                   token_length_o, literal_value_o, number_overflow_o,
                   unknown_char_o, last_of_run_o);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    send_text("{}();,+-*/%<>!");
    send_text("a=b==c=");
    send_byte(8'hFF, 1'b0);
    send_text("\"x\ny\" 12.5 7.x 3.");
    finish_source();
    send_text("if else while return const true false define definex abc9 ");
    send_text("99999999999 2147483647 0\t\r\f\v@#$");
    send_byte(8'h80, 1'b0);
    send_text("\"open\n");
    finish_source();
    send_text("x"); finish_source();
    send_text("="); finish_source();
    send_text("5"); finish_source();
    finish_source();
  endtask

  function automatic logic [7:0] pick_byte();
    string pool;
    pool = "{}();,+-*/%<>!= =.\"\n\tabcdefiltrunswhoxyzAZ0123456789  ";
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      default: return pool[$urandom_range(0, pool.len() - 1)];
    endcase
  endfunction

  function automatic string pick_word();
    string words [16];
    words = '{"if", "else", "while", "return", "const", "true", "false",
              "define", "x1", "foo", "123", "4.25", "\"str\"", "==", "= ",
              "defines"};
    return words[$urandom_range(0, 15)];
  endfunction

  task automatic test_random();
    int sent;
    sent = 0;
    random_stall = 1;
    while (sent < 300) begin
      if ($urandom_range(0, 2) == 0) begin
        send_byte(pick_byte(), 1'b0);
        sent++;
      end else begin
        string w;
        w = pick_word();
        send_text(w);
        send_byte(" ", 1'b0);
        sent += w.len() + 1;
      end
      if ($urandom_range(0, 40) == 0) begin
        finish_source();
        sent++;
      end
    end
    finish_source();
  endtask

  task automatic test_backpressure();
    hold_off = 60;
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(0, 1) ? "+" : "x"), 1'b0);
    finish_source();
  endtask

  initial begin
    int guard;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    idle_push();
    guard = 0;
    while (expected_tokens.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_tokens.size() == 0 && empty) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
